[rtl/bmhq_pkg.sv]
`timescale 1ns / 1ps

package bmhq_pkg;

  localparam int DATA_W       = 32;
  localparam int CAPACITY_DEF = 64;
  localparam int COUNT_OUT_W  = 7;
  localparam int STATUS_W     = 2;
  localparam int IN_TDATA_W   = 32;
  localparam int IN_TUSER_W   = 1;
  localparam int OUT_TDATA_W  = 48;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  typedef struct packed {
    logic              insert;
    logic              remove;
    logic [DATA_W-1:0] key;
  } cell_ctl_t;

  typedef struct packed {
    logic [DATA_W-1:0] val;
    logic              valid;
    logic              keep;
  } cell_link_t;

endpackage

[rtl/bmhq_cell.sv]
`timescale 1ns / 1ps

module bmhq_cell (
  input  logic                 clk,
  input  logic                 rst,
  input  bmhq_pkg::cell_ctl_t  ctl,
  input  bmhq_pkg::cell_link_t from_prev,
  input  bmhq_pkg::cell_link_t from_next,
  output bmhq_pkg::cell_link_t link
);

  logic [bmhq_pkg::DATA_W-1:0] val;
  logic                        valid;
  logic [bmhq_pkg::DATA_W-1:0] val_next;
  logic                        valid_next;
  logic                        keep;

  assign keep = valid && !($signed(ctl.key) > $signed(val));

  always_comb begin
    val_next   = val;
    valid_next = valid;
    if (ctl.insert) begin
      if (!keep) begin
        if (from_prev.keep) begin
          val_next   = ctl.key;
          valid_next = 1'b1;
        end else begin
          val_next   = from_prev.val;
          valid_next = from_prev.valid;
        end
      end
    end else if (ctl.remove) begin
      val_next   = from_next.val;
      valid_next = from_next.valid;
    end
  end

  always_ff @(posedge clk) begin
    val <= val_next;
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  assign link.val   = val;
  assign link.valid = valid;
  assign link.keep  = keep;

endmodule

[rtl/bmhq_chain.sv]
`timescale 1ns / 1ps

module bmhq_chain #(
  parameter int CAPACITY = bmhq_pkg::CAPACITY_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  bmhq_pkg::cell_ctl_t         ctl,
  output logic [bmhq_pkg::DATA_W-1:0] head_val,
  output logic                        head_valid
);

  bmhq_pkg::cell_link_t links [CAPACITY];
  bmhq_pkg::cell_link_t head_in;
  bmhq_pkg::cell_link_t tail_in;

  assign head_in.val   = '0;
  assign head_in.valid = 1'b0;
  assign head_in.keep  = 1'b1;
  assign tail_in.val   = '0;
  assign tail_in.valid = 1'b0;
  assign tail_in.keep  = 1'b0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    bmhq_pkg::cell_link_t prev_link;
    bmhq_pkg::cell_link_t next_link;

    if (i == 0) begin : g_head
      assign prev_link = head_in;
    end else begin : g_body
      assign prev_link = links[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign next_link = tail_in;
    end else begin : g_mid
      assign next_link = links[i+1];
    end

    bmhq_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .from_prev (prev_link),
      .from_next (next_link),
      .link      (links[i])
    );
  end

  assign head_val   = links[0].val;
  assign head_valid = links[0].valid;

endmodule

[rtl/binary_max_heap_queue.sv]
`timescale 1ns / 1ps

// Max priority queue of up to CAPACITY signed 32-bit keys, held sorted in a
// row of CAPACITY cells. On each accepted transaction, an insert
// shifts the smaller keys one cell down the row and drops the new key into
// the gap, a remove shifts the whole row up by one cell, so the largest key
// is always in the first cell. Each input transaction yields one result
// transaction (removed key, status, entry count) through an output register;
// a new input is taken every cycle while the result side keeps up. Inserts
// into a full queue are dropped with status 2, removes from an empty queue
// report status 1.
module binary_max_heap_queue #(
  parameter int CAPACITY = bmhq_pkg::CAPACITY_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [bmhq_pkg::IN_TDATA_W-1:0]  s_tdata,  // [31:0] value
  input  logic [bmhq_pkg::IN_TUSER_W-1:0]  s_tuser,  // [0] op
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [bmhq_pkg::OUT_TDATA_W-1:0] m_tdata   // [31:0] top_value,
                                                     // [33:32] status,
                                                     // [40:34] count_after
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
  localparam int PAD_W = bmhq_pkg::OUT_TDATA_W - bmhq_pkg::DATA_W
                         - bmhq_pkg::STATUS_W - bmhq_pkg::COUNT_OUT_W;

  logic [CNT_W-1:0]                   count;
  logic [CNT_W-1:0]                   count_next;
  logic [CNT_W+bmhq_pkg::COUNT_OUT_W-1:0] count_ext;
  logic                               accept;
  logic                               full;
  logic                               empty;
  bmhq_pkg::cell_ctl_t                ctl;
  logic [bmhq_pkg::DATA_W-1:0]        head_val;
  logic                               head_valid;
  logic [bmhq_pkg::DATA_W-1:0]        res_top;
  logic [bmhq_pkg::DATA_W-1:0]        res_top_next;
  logic [bmhq_pkg::STATUS_W-1:0]      res_status;
  logic [bmhq_pkg::STATUS_W-1:0]      res_status_next;
  logic [bmhq_pkg::COUNT_OUT_W-1:0]   res_count;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign full     = (count == CAP_CNT);
  assign empty    = (count == '0);

  assign ctl.insert = accept && (s_tuser[0] == bmhq_pkg::OP_INSERT) && !full;
  assign ctl.remove = accept && (s_tuser[0] == bmhq_pkg::OP_REMOVE) && !empty;
  assign ctl.key    = s_tdata[bmhq_pkg::DATA_W-1:0];

  bmhq_chain #(
    .CAPACITY (CAPACITY)
  ) u_chain (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .head_val   (head_val),
    .head_valid (head_valid)
  );

  always_comb begin
    count_next      = count;
    res_top_next    = '0;
    res_status_next = bmhq_pkg::STATUS_OK;
    if (s_tuser[0] == bmhq_pkg::OP_INSERT) begin
      if (full) begin
        res_status_next = bmhq_pkg::STATUS_FULL;
      end else begin
        count_next = count + CNT_W'(1);
      end
    end else begin
      if (empty) begin
        res_status_next = bmhq_pkg::STATUS_EMPTY;
      end else begin
        count_next   = count - CNT_W'(1);
        res_top_next = head_val;
      end
    end
  end

  assign count_ext = {{bmhq_pkg::COUNT_OUT_W{1'b0}}, count_next};

  always_ff @(posedge clk) begin
    if (accept) begin
      res_top    <= res_top_next;
      res_status <= res_status_next;
      res_count  <= count_ext[bmhq_pkg::COUNT_OUT_W-1:0];
    end
    if (rst) begin
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        count <= count_next;
      end
      if (accept) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  assign m_tdata = {{PAD_W{1'b0}}, res_count, res_status, res_top};

  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    count <= CAP_CNT)
    else $error("entry count above capacity");

  a_head_tracks_count : assert property (@(posedge clk) disable iff (rst)
    head_valid == (count != '0))
    else $error("first cell occupancy disagrees with entry count");

  a_result_follows : assert property (@(posedge clk) disable iff (rst)
    accept |=> m_tvalid)
    else $error("accepted transaction gave no result");

  a_empty_zero : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (res_status == bmhq_pkg::STATUS_EMPTY) |->
      (res_count == '0) && (res_top == '0))
    else $error("empty status with nonzero count or key");

endmodule
